// File: rtl/blp_pkg.sv
package blp_pkg;

  localparam int PAT_W  = 5;
  localparam int DIV_W  = 8;

  // Pattern code boundaries
  localparam logic [PAT_W-1:0] PAT_OFF          = 5'd0;
  localparam logic [PAT_W-1:0] PAT_GREEN        = 5'd1;
  localparam logic [PAT_W-1:0] PAT_RED          = 5'd2;
  localparam logic [PAT_W-1:0] PAT_STEADY_LAST  = 5'd3;
  localparam logic [PAT_W-1:0] PAT_SLOW_FIRST   = 5'd4;
  localparam logic [PAT_W-1:0] PAT_SLOW_LAST    = 5'd9;
  localparam logic [PAT_W-1:0] PAT_FAST_FIRST   = 5'd10;
  localparam logic [PAT_W-1:0] PAT_FAST_LAST    = 5'd15;
  localparam logic [PAT_W-1:0] PAT_PULSE_FIRST  = 5'd16;
  localparam logic [PAT_W-1:0] PAT_COUNT        = 5'd25;

  localparam logic [DIV_W-1:0] SLOW_DIV_RESET   = 8'd5;

  // Toggle rule codes
  localparam logic [2:0] TGL_GREEN        = 3'd0;
  localparam logic [2:0] TGL_RED          = 3'd1;
  localparam logic [2:0] TGL_ORANGE       = 3'd2;
  localparam logic [2:0] TGL_GREEN_RED    = 3'd3;
  localparam logic [2:0] TGL_GREEN_ORANGE = 3'd4;

  // Pulse colour codes
  localparam logic [1:0] COL_GREEN  = 2'd0;
  localparam logic [1:0] COL_RED    = 2'd1;
  localparam logic [1:0] COL_ORANGE = 2'd2;

  typedef struct packed {
    logic             request_valid;
    logic [PAT_W-1:0] request_pattern;
  } req_t;

  typedef struct packed {
    logic green;
    logic red;
  } led_t;

  typedef struct packed {
    logic [2:0] pulses;
    logic [1:0] colour;
  } pulse_sel_t;

  // Next LED state for one toggle rule
  function automatic led_t apply_toggle(logic [2:0] kind, led_t cur);
    led_t nxt;
    unique case (kind)
      TGL_GREEN:        nxt = cur.green ? '{1'b0, 1'b0} : '{1'b1, 1'b0};
      TGL_RED:          nxt = cur.red   ? '{1'b0, 1'b0} : '{1'b0, 1'b1};
      TGL_ORANGE:       nxt = cur.red   ? '{1'b0, 1'b0} : '{1'b1, 1'b1};
      TGL_GREEN_RED:    nxt = cur.green ? '{1'b0, 1'b1} : '{1'b1, 1'b0};
      TGL_GREEN_ORANGE: nxt = cur.red   ? '{1'b1, 1'b0} : '{1'b1, 1'b1};
      default:          nxt = cur.green ? '{1'b0, 1'b1} : '{1'b1, 1'b1};
    endcase
    return nxt;
  endfunction

  // Pulse count and colour for a pulse pattern offset (0..8)
  function automatic pulse_sel_t pulse_decode(logic [3:0] idx);
    pulse_sel_t s;
    unique case (idx)
      4'd0:    s = '{3'd2, COL_GREEN};
      4'd1:    s = '{3'd2, COL_RED};
      4'd2:    s = '{3'd2, COL_ORANGE};
      4'd3:    s = '{3'd3, COL_GREEN};
      4'd4:    s = '{3'd3, COL_RED};
      4'd5:    s = '{3'd3, COL_ORANGE};
      4'd6:    s = '{3'd4, COL_GREEN};
      4'd7:    s = '{3'd4, COL_RED};
      default: s = '{3'd4, COL_ORANGE};
    endcase
    return s;
  endfunction

endpackage

// File: rtl/blp_ifs.sv
interface blp_req_if;
  import blp_pkg::*;
  logic             valid;
  logic             ready;
  logic             request_valid;
  logic [PAT_W-1:0] request_pattern;

  modport source (output valid, output request_valid, output request_pattern, input ready);
  modport sink   (input valid, input request_valid, input request_pattern, output ready);
endinterface

interface blp_res_if;
  import blp_pkg::*;
  logic             valid;
  logic             ready;
  logic             green_pin;
  logic             red_pin;
  logic [PAT_W-1:0] active_pattern;

  modport source (output valid, output green_pin, output red_pin, output active_pattern,
                  input ready);
  modport sink   (input valid, input green_pin, input red_pin, input active_pattern,
                  output ready);
endinterface

// File: rtl/blp_in_stage.sv
module blp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  blp_req_if.sink       in_chan,
  output logic          req_valid,
  output blp_pkg::req_t req,
  input  logic          req_take
);
  import blp_pkg::*;

  logic valid_r;
  logic valid_nxt;
  req_t req_r;

  // Accept a new item whenever the held one is empty or leaving
  assign in_chan.ready = !valid_r || req_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_chan.ready) begin
      valid_nxt = in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      req_r.request_valid   <= in_chan.request_valid;
      req_r.request_pattern <= in_chan.request_pattern;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;
endmodule

// File: rtl/blp_core.sv
module blp_core #(
  parameter int MAX_PULSES = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          req_valid,
  input  blp_pkg::req_t req,
  output logic          req_take,
  blp_res_if.source     out_chan
);
  import blp_pkg::*;

  localparam int PC_W = $clog2(4 * MAX_PULSES);
  localparam int CW   = PC_W + 1;

  logic [DIV_W-1:0] slow_div_r;
  led_t             led_r, led_nxt;
  logic [PAT_W-1:0] pat_r, pat_nxt;
  logic [DIV_W-1:0] slow_cnt_r, slow_cnt_nxt;
  logic [PC_W-1:0]  pulse_cnt_r, pulse_cnt_nxt;
  logic             out_valid_r;
  led_t             out_led_r;
  logic [PAT_W-1:0] out_pat_r;

  logic [PAT_W-1:0] pat_req;
  logic [DIV_W-1:0] slow_inc;
  pulse_sel_t       psel;
  logic [PAT_W-1:0] pidx;
  logic [CW-1:0]    pulses_c, blink, total, pc_plus, pc_base;

  // Take the held item when the result register is free or draining
  assign req_take = req_valid && (!out_valid_r || out_chan.ready);

  // Compute the next LED state for one tick
  always_comb begin
    pat_req       = req.request_valid ? req.request_pattern : pat_r;
    pat_nxt       = (pat_req >= PAT_COUNT) ? PAT_OFF : pat_req;
    led_nxt       = led_r;
    slow_cnt_nxt  = slow_cnt_r;
    pulse_cnt_nxt = pulse_cnt_r;
    slow_inc      = slow_cnt_r + 8'd1;
    pidx          = pat_nxt - PAT_PULSE_FIRST;
    psel          = pulse_decode(pidx[3:0]);
    pulses_c      = (CW'(psel.pulses) > CW'(MAX_PULSES)) ? CW'(MAX_PULSES)
                                                         : CW'(psel.pulses);
    blink         = pulses_c << 1;
    total         = pulses_c << 2;
    pc_plus       = CW'(pulse_cnt_r) + CW'(1);
    pc_base       = (pc_plus >= total) ? '0 : CW'(pulse_cnt_r);
    priority if (pat_nxt == PAT_OFF) begin
      led_nxt = '{1'b0, 1'b0};
    end else if (pat_nxt <= PAT_STEADY_LAST) begin
      led_nxt = '{(pat_nxt != PAT_RED), (pat_nxt != PAT_GREEN)};
    end else if (pat_nxt <= PAT_SLOW_LAST) begin
      if (slow_cnt_r == '0) begin
        led_nxt = apply_toggle(3'(pat_nxt - PAT_SLOW_FIRST), led_r);
      end
      slow_cnt_nxt = (slow_inc >= slow_div_r) ? '0 : slow_inc;
    end else if (pat_nxt <= PAT_FAST_LAST) begin
      led_nxt = apply_toggle(3'(pat_nxt - PAT_FAST_FIRST), led_r);
    end else begin
      if (!pc_base[0] && (pc_base < blink)) begin
        led_nxt = '{(psel.colour != COL_RED), (psel.colour != COL_GREEN)};
      end else begin
        led_nxt = '{1'b0, 1'b0};
      end
      pulse_cnt_nxt = PC_W'(pc_base + CW'(1));
    end
  end

  // Hold the divider and pattern state; advance on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_div_r  <= SLOW_DIV_RESET;
      led_r       <= '{1'b0, 1'b0};
      pat_r       <= PAT_OFF;
      slow_cnt_r  <= '0;
      pulse_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        slow_div_r <= cfg_wdata;
      end
      if (req_take) begin
        led_r       <= led_nxt;
        pat_r       <= pat_nxt;
        slow_cnt_r  <= slow_cnt_nxt;
        pulse_cnt_r <= pulse_cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (req_take) begin
      out_led_r <= led_nxt;
      out_pat_r <= pat_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.green_pin      = !out_led_r.green;
  assign out_chan.red_pin        = !out_led_r.red;
  assign out_chan.active_pattern = out_pat_r;
endmodule

// File: rtl/bicolor_led_pattern_generator.sv
// Channel    Dir  Payload                                   Handshake
// in_chan    in   request_valid, request_pattern[4:0]       valid / ready
// out_chan   out  green_pin, red_pin, active_pattern[4:0]   valid / ready
// cfg_*      in   cfg_wdata[7:0] = slow_divider             cfg_we, no wait
//
// One item per cycle sustained while out_chan is ready; an accepted item passes through
// the input register, then the result register behind the LED state logic.
// Reset clears LED state, pattern and counters and sets slow_divider to 5.
// A stalled output holds its result; the input register takes one more item and
// holds it, after which input ready follows output ready until the result drains.
module bicolor_led_pattern_generator #(
  parameter int MAX_PULSES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  blp_req_if.sink    in_chan,
  blp_res_if.source  out_chan
);
  import blp_pkg::*;

  logic req_valid;
  logic req_take;
  req_t req;

  blp_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take)
  );

  blp_core #(
    .MAX_PULSES (MAX_PULSES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (req_take),
    .out_chan  (out_chan)
  );
endmodule

// File: sim/tb.sv
import blp_pkg::*;

typedef struct packed {
  logic             green_pin;
  logic             red_pin;
  logic [PAT_W-1:0] active_pattern;
} led_result_t;

// Tracks LED pattern state and holds predicted pin levels in accept order
class led_pattern_predictor;
  localparam int PULSE_CAP = 4;

  logic [DIV_W-1:0] divider;
  logic             green_on;
  logic             red_on;
  logic [PAT_W-1:0] pattern;
  logic [7:0]       slow_cnt;
  logic [7:0]       pulse_cnt;
  led_result_t      expected_leds[$];
  int               errors;

  function new();
    divider   = SLOW_DIV_RESET;
    green_on  = 1'b0;
    red_on    = 1'b0;
    pattern   = PAT_OFF;
    slow_cnt  = '0;
    pulse_cnt = '0;
    errors    = 0;
  endfunction

  function void set_divider(logic [DIV_W-1:0] value);
    divider = value;
  endfunction

  function int pending();
    return expected_leds.size();
  endfunction

  // Pick the next colour from the present one for one toggle rule
  function void toggle(logic [2:0] kind);
    case (kind)
      TGL_GREEN: begin
        red_on   = 1'b0;
        green_on = !green_on;
      end
      TGL_RED: begin
        green_on = 1'b0;
        red_on   = !red_on;
      end
      TGL_ORANGE: begin
        green_on = !red_on;
        red_on   = !red_on;
      end
      TGL_GREEN_RED: begin
        red_on   = green_on;
        green_on = !green_on;
      end
      TGL_GREEN_ORANGE: begin
        green_on = 1'b1;
        red_on   = !red_on;
      end
      // red/orange
      default: begin
        red_on   = 1'b1;
        green_on = !green_on;
      end
    endcase
  endfunction

  // Advance one pattern tick and queue the pins it produces
  function void note_request(logic req_valid, logic [PAT_W-1:0] code);
    led_result_t res;
    logic [3:0]  idx;
    logic [1:0]  colour;
    int          pulses;
    int          blink;
    if (req_valid) pattern = code;
    // unknown codes fall back to off
    if (pattern >= PAT_COUNT) pattern = PAT_OFF;

    if (pattern == PAT_OFF) begin
      green_on = 1'b0;
      red_on   = 1'b0;
    end else if (pattern <= PAT_STEADY_LAST) begin
      green_on = (pattern != PAT_RED);
      red_on   = (pattern != PAT_GREEN);
    end else if (pattern <= PAT_SLOW_LAST) begin
      if (slow_cnt == 0) toggle(3'(pattern - PAT_SLOW_FIRST));
      slow_cnt = slow_cnt + 8'd1;
      // a zero divider acts as one; a lowered divider clears here
      if (slow_cnt >= divider) slow_cnt = '0;
    end else if (pattern <= PAT_FAST_LAST) begin
      toggle(3'(pattern - PAT_FAST_FIRST));
    end else begin
      idx    = 4'(pattern - PAT_PULSE_FIRST);
      pulses = 2 + idx / 3;
      colour = 2'(idx % 3);
      if (pulses > PULSE_CAP) pulses = PULSE_CAP;
      blink = pulses * 2;
      if (int'(pulse_cnt) + 1 >= blink * 2) pulse_cnt = '0;
      if (!pulse_cnt[0] && int'(pulse_cnt) < blink) begin
        green_on = (colour != COL_RED);
        red_on   = (colour != COL_GREEN);
      end else begin
        green_on = 1'b0;
        red_on   = 1'b0;
      end
      pulse_cnt = pulse_cnt + 8'd1;
    end

    res.green_pin      = !green_on;
    res.red_pin        = !red_on;
    res.active_pattern = pattern;
    expected_leds.push_back(res);
  endfunction

  // Compare one delivered item against the oldest prediction
  function void check_leds(logic green_pin, logic red_pin, logic [PAT_W-1:0] active);
    led_result_t exp_res;
    if (expected_leds.size() == 0) begin
      $display("%0t unexpected result: green %0b red %0b pattern %0d",
               $time, green_pin, red_pin, active);
      errors++;
      return;
    end
    exp_res = expected_leds.pop_front();
    if (green_pin !== exp_res.green_pin) begin
      $display("%0t green_pin mismatch: expected %0b actual %0b",
               $time, exp_res.green_pin, green_pin);
      errors++;
    end
    if (red_pin !== exp_res.red_pin) begin
      $display("%0t red_pin mismatch: expected %0b actual %0b",
               $time, exp_res.red_pin, red_pin);
      errors++;
    end
    if (active !== exp_res.active_pattern) begin
      $display("%0t active_pattern mismatch: expected %0d actual %0d",
               $time, exp_res.active_pattern, active);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SEG_ITEMS    = 205;
  localparam int SEG_COUNT    = 6;
  localparam int SETTLE_TICKS = 6;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [DIV_W-1:0]     cfg_wdata;
  int                   send_idle;
  int                   recv_idle;
  int                   cycles = 0;
  led_pattern_predictor leds;

  blp_req_if in_if();
  blp_res_if out_if();

  bicolor_led_pattern_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #2 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check delivered items and stall the output at random
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      leds.check_leds(out_if.green_pin, out_if.red_pin, out_if.active_pattern);
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Offer one tick, idling at random first; valid stays high after accept
  task automatic send_tick(input logic req_valid, input logic [PAT_W-1:0] code);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.request_valid   <= req_valid;
    in_if.request_pattern <= code;
    do @(posedge clk); while (!in_if.ready);
    leds.note_request(req_valid, code);
  endtask

  // Hold off input until every predicted item has come out
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (leds.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_divider(input logic [DIV_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    leds.set_divider(value);
  endtask

  initial begin
    logic [DIV_W-1:0] seg_div[SEG_COUNT];
    logic [PAT_W-1:0] code;
    logic             req_valid;
    int               hold;

    seg_div = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd2, 8'd7};
    leds = new();
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    in_if.valid           <= 1'b0;
    in_if.request_valid   <= 1'b0;
    in_if.request_pattern <= '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk every code once at the reset divider, then unknown codes
    for (int c = 0; c < PAT_COUNT; c++) send_tick(1'b1, PAT_W'(c));
    send_tick(1'b1, 5'd31);
    send_tick(1'b0, 5'd31);
    send_tick(1'b1, PAT_COUNT);
    drain();

    // Random phases: requests held for a random number of ticks
    hold = 0;
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      case (seg / 2)
        0: begin
          send_idle = 17;
          recv_idle = 47;
        end
        1: begin
          send_idle = 47;
          recv_idle = 17;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_divider(seg_div[seg]);
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (i == SEG_ITEMS / 2) drain();
        if (hold == 0) begin
          req_valid = 1'b1;
          code = ($urandom_range(9) == 0) ? PAT_W'($urandom_range(31))
                                          : PAT_W'($urandom_range(24));
          hold = $urandom_range(30);
        end else begin
          // noise on the pattern field while no request is made
          req_valid = 1'b0;
          code = PAT_W'($urandom);
          hold--;
        end
        send_tick(req_valid, code);
      end
      drain();
    end

    if (leds.errors == 0 && leds.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
